// ===== design/kbd_pkg.sv =====
// Shared types, codes and helpers of the keyboard report differencer.
package kbd_pkg;

  localparam int unsigned KEY_SLOTS_DEF = 6;

  localparam int unsigned IN_HDR_W = 14;
  localparam int unsigned KEY_LSB  = 14;
  localparam int unsigned OUT_W    = 32;

  localparam logic [3:0] MIN_BYTES       = 4'd4;
  localparam logic [7:0] FIRST_REAL_CODE = 8'd4;

  localparam logic [7:0] CODE_NUM    = 8'h53;
  localparam logic [7:0] CODE_CAPS   = 8'h39;
  localparam logic [7:0] CODE_SCROLL = 8'h47;

  localparam logic [2:0] LED_NUM    = 3'b001;
  localparam logic [2:0] LED_CAPS   = 3'b010;
  localparam logic [2:0] LED_SCROLL = 3'b100;

  typedef enum logic [2:0] {
    EV_MOD   = 3'd0,
    EV_DOWN  = 3'd1,
    EV_UP    = 3'd2,
    EV_LED   = 3'd3,
    EV_RETRY = 3'd4
  } kbd_event_e;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_NO_RESP = 2'd1,
    ST_TIMEOUT = 2'd2,
    ST_ERROR   = 2'd3
  } kbd_status_e;

  typedef enum logic {
    REQ_REPORT  = 1'b0,
    REQ_SESSION = 1'b1
  } kbd_req_e;

  typedef struct packed {
    logic       add;
    logic       rem;
    logic [2:0] led_mask;
  } kbd_lane_t;

  typedef struct packed {
    logic       retry;
    logic       mod_chg;
    logic [7:0] mods;
    logic [7:0] prev_mods;
  } kbd_job_t;

  function automatic logic [2:0] kbd_led_mask(input logic [7:0] code);
    logic [2:0] m;
    m = 3'b000;
    if (code == CODE_NUM) begin
      m = LED_NUM;
    end else if (code == CODE_CAPS) begin
      m = LED_CAPS;
    end else if (code == CODE_SCROLL) begin
      m = LED_SCROLL;
    end
    return m;
  endfunction

endpackage

// ===== design/kbd_lane.sv =====
// One slot lane: finds whether the slot's new code was pressed and its old code released.
module kbd_lane import kbd_pkg::*; #(
  parameter int unsigned KEY_SLOTS = KEY_SLOTS_DEF
) (
  input  logic [7:0] new_key_i,
  input  logic [7:0] old_key_i,
  input  logic [7:0] keys_i [KEY_SLOTS],
  input  logic [7:0] prev_keys_i [KEY_SLOTS],
  output kbd_lane_t  res_o
);

  logic seen_new;
  logic seen_old;

  always_comb begin
    seen_new = 1'b0;
    seen_old = 1'b0;
    for (int j = 0; j < KEY_SLOTS; j++) begin
      if (prev_keys_i[j] == new_key_i) seen_new = 1'b1;
      if (keys_i[j] == old_key_i) seen_old = 1'b1;
    end
    res_o.add      = (new_key_i >= FIRST_REAL_CODE) && !seen_new;
    res_o.rem      = (old_key_i >= FIRST_REAL_CODE) && !seen_old;
    res_o.led_mask = kbd_led_mask(new_key_i);
  end

endmodule

// ===== design/kbd_merge.sv =====
// Merge stage: orders the lane findings into events and drives the output register.
module kbd_merge import kbd_pkg::*; #(
  parameter int unsigned KEY_SLOTS = KEY_SLOTS_DEF
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            job_valid_i,
  output logic            job_ready_o,
  input  kbd_job_t        job_i,
  input  kbd_lane_t       lane_i [KEY_SLOTS],
  input  logic [7:0]      keys_i [KEY_SLOTS],
  input  logic [7:0]      prev_keys_i [KEY_SLOTS],
  output logic            m_tvalid_o,
  input  logic            m_tready_i,
  output logic [OUT_W-1:0] m_tdata_o,  // old_modifiers, event_modifiers, key_code, led_bits
  output logic [2:0]      m_tuser_o,   // event_kind
  output logic            m_tlast_o
);

  localparam int unsigned SLOT_W = (KEY_SLOTS > 1) ? $clog2(KEY_SLOTS) : 1;

  logic                 retry_pend_q, mod_pend_q;
  logic [KEY_SLOTS-1:0] led_pend_q, down_pend_q, up_pend_q;
  logic                 retry_pend_d, mod_pend_d;
  logic [KEY_SLOTS-1:0] led_pend_d, down_pend_d, up_pend_d;
  logic [KEY_SLOTS-1:0] pend_any;

  logic [7:0] keys_q [KEY_SLOTS];
  logic [7:0] prev_q [KEY_SLOTS];
  logic [2:0] mask_q [KEY_SLOTS];
  logic [7:0] mods_q, prev_mods_q;
  logic [2:0] leds_q, leds_d;

  logic [SLOT_W-1:0] idx;
  logic              have_ev, last, advance, job_load;

  kbd_event_e kind_d, kind_q;
  logic [7:0] oldm_d, evm_d, code_d;
  logic [7:0] oldm_q, evm_q, code_q;
  logic [2:0] ledo_q;
  logic       last_q, out_valid_q;

  always_comb begin
    pend_any = led_pend_q | down_pend_q | up_pend_q;
    idx = '0;
    for (int i = KEY_SLOTS - 1; i >= 0; i--) begin
      if (pend_any[i]) idx = SLOT_W'(i);
    end

    retry_pend_d = retry_pend_q;
    mod_pend_d   = mod_pend_q;
    led_pend_d   = led_pend_q;
    down_pend_d  = down_pend_q;
    up_pend_d    = up_pend_q;
    leds_d       = leds_q;
    kind_d       = EV_UP;
    oldm_d       = 8'd0;
    evm_d        = 8'd0;
    code_d       = 8'd0;

    priority if (retry_pend_q) begin
      kind_d       = EV_RETRY;
      retry_pend_d = 1'b0;
    end else if (mod_pend_q) begin
      kind_d     = EV_MOD;
      oldm_d     = prev_mods_q;
      evm_d      = mods_q;
      mod_pend_d = 1'b0;
    end else if (led_pend_q[idx]) begin
      kind_d          = EV_LED;
      code_d          = keys_q[idx];
      leds_d          = leds_q ^ mask_q[idx];
      led_pend_d[idx] = 1'b0;
    end else if (down_pend_q[idx]) begin
      kind_d           = EV_DOWN;
      evm_d            = mods_q;
      code_d           = keys_q[idx];
      down_pend_d[idx] = 1'b0;
    end else begin
      kind_d         = EV_UP;
      evm_d          = prev_mods_q;
      code_d         = prev_q[idx];
      up_pend_d[idx] = 1'b0;
    end

    have_ev = retry_pend_q | mod_pend_q | (|pend_any);
    last    = !(retry_pend_d | mod_pend_d | (|(led_pend_d | down_pend_d | up_pend_d)));
    advance = have_ev && (!out_valid_q || m_tready_i);
  end

  assign job_ready_o = !have_ev || (advance && last);
  assign job_load    = job_valid_i && job_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      retry_pend_q <= 1'b0;
      mod_pend_q   <= 1'b0;
      led_pend_q   <= '0;
      down_pend_q  <= '0;
      up_pend_q    <= '0;
      leds_q       <= 3'b000;
      out_valid_q  <= 1'b0;
    end else begin
      if (job_load) begin
        retry_pend_q <= job_i.retry;
        mod_pend_q   <= job_i.mod_chg;
        for (int i = 0; i < KEY_SLOTS; i++) begin
          led_pend_q[i]  <= !job_i.retry && lane_i[i].add && (lane_i[i].led_mask != 3'b000);
          down_pend_q[i] <= !job_i.retry && lane_i[i].add;
          up_pend_q[i]   <= !job_i.retry && lane_i[i].rem;
        end
      end else if (advance) begin
        retry_pend_q <= retry_pend_d;
        mod_pend_q   <= mod_pend_d;
        led_pend_q   <= led_pend_d;
        down_pend_q  <= down_pend_d;
        up_pend_q    <= up_pend_d;
      end
      if (advance) begin
        leds_q      <= leds_d;
        out_valid_q <= 1'b1;
      end else if (m_tready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (job_load) begin
      mods_q      <= job_i.mods;
      prev_mods_q <= job_i.prev_mods;
      for (int i = 0; i < KEY_SLOTS; i++) begin
        keys_q[i] <= keys_i[i];
        prev_q[i] <= prev_keys_i[i];
        mask_q[i] <= lane_i[i].led_mask;
      end
    end
    if (advance) begin
      kind_q <= kind_d;
      oldm_q <= oldm_d;
      evm_q  <= evm_d;
      code_q <= code_d;
      ledo_q <= leds_d;
      last_q <= last;
    end
  end

  assign m_tvalid_o = out_valid_q;
  assign m_tdata_o  = {5'b00000, ledo_q, code_q, evm_q, oldm_q};
  assign m_tuser_o  = kind_q;
  assign m_tlast_o  = last_q;

endmodule

// ===== design/keyboard_report_diff_unit.sv =====
// Top level of the keyboard report differencer: stored report, slot lanes and merge stage.
// The first event of a report passes the pending registers, then the output register, to m_axis.
// One event per cycle while m_axis_tready does not stall; a report holds the merge stage until
// all its events (up to 3*KEY_SLOTS+1) are sent, and the next transfer is taken in the cycle its last
// event is registered. Items without events (drops, session start) do not load the merge stage.
// Reset clears the stored report, the lock LEDs, pending events and the output register.
module keyboard_report_diff_unit import kbd_pkg::*; #(
  parameter int unsigned KEY_SLOTS = KEY_SLOTS_DEF,
  localparam int unsigned IN_W = ((IN_HDR_W + 8 * KEY_SLOTS + 7) / 8) * 8
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             s_axis_tvalid,
  output logic             s_axis_tready,
  input  logic [IN_W-1:0]  s_axis_tdata,  // trans_status, byte_count, modifier_bits, key_0..
  input  logic             s_axis_tuser,  // req_type
  output logic             m_axis_tvalid,
  input  logic             m_axis_tready,
  output logic [OUT_W-1:0] m_axis_tdata,  // old_modifiers, event_modifiers, key_code, led_bits
  output logic [2:0]       m_axis_tuser,  // event_kind
  output logic             m_axis_tlast   // last_event
);

  logic [1:0] status;
  logic [3:0] byte_count;
  logic [7:0] mods;
  logic [7:0] keys [KEY_SLOTS];

  logic [7:0] prev_mods_q;
  logic [7:0] prev_keys_q [KEY_SLOTS];

  kbd_lane_t            lane_res [KEY_SLOTS];
  logic [KEY_SLOTS-1:0] add_vec, rem_vec;

  logic     is_session, is_retry, is_good, mod_chg, any_ev, accept, job_valid, job_ready;
  kbd_job_t job;

  assign status     = s_axis_tdata[1:0];
  assign byte_count = s_axis_tdata[5:2];
  assign mods       = s_axis_tdata[13:6];

  for (genvar i = 0; i < KEY_SLOTS; i++) begin : g_lane
    assign keys[i]    = s_axis_tdata[KEY_LSB + 8 * i +: 8];
    assign add_vec[i] = lane_res[i].add;
    assign rem_vec[i] = lane_res[i].rem;

    kbd_lane #(
      .KEY_SLOTS (KEY_SLOTS)
    ) u_lane (
      .new_key_i   (keys[i]),
      .old_key_i   (prev_keys_q[i]),
      .keys_i      (keys),
      .prev_keys_i (prev_keys_q),
      .res_o       (lane_res[i])
    );
  end

  assign is_session = (s_axis_tuser == REQ_SESSION);
  assign is_retry   = !is_session && ((status == ST_NO_RESP) || (status == ST_TIMEOUT));
  assign is_good    = !is_session && (status == ST_OK) && (byte_count >= MIN_BYTES);
  assign mod_chg    = (mods != prev_mods_q);
  assign any_ev     = mod_chg || (|add_vec) || (|rem_vec);
  assign job_valid  = s_axis_tvalid && (is_retry || (is_good && any_ev));
  assign accept     = s_axis_tvalid && s_axis_tready;

  assign s_axis_tready = job_ready;

  always_comb begin
    job.retry     = is_retry;
    job.mod_chg   = is_good && mod_chg;
    job.mods      = mods;
    job.prev_mods = prev_mods_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_mods_q <= 8'd0;
      for (int i = 0; i < KEY_SLOTS; i++) prev_keys_q[i] <= 8'd0;
    end else if (accept) begin
      if (is_session) begin
        prev_mods_q <= 8'd0;
        for (int i = 0; i < KEY_SLOTS; i++) prev_keys_q[i] <= 8'd0;
      end else if (is_good) begin
        prev_mods_q <= mods;
        for (int i = 0; i < KEY_SLOTS; i++) prev_keys_q[i] <= keys[i];
      end
    end
  end

  kbd_merge #(
    .KEY_SLOTS (KEY_SLOTS)
  ) u_merge (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .job_valid_i (job_valid),
    .job_ready_o (job_ready),
    .job_i       (job),
    .lane_i      (lane_res),
    .keys_i      (keys),
    .prev_keys_i (prev_keys_q),
    .m_tvalid_o  (m_axis_tvalid),
    .m_tready_i  (m_axis_tready),
    .m_tdata_o   (m_axis_tdata),
    .m_tuser_o   (m_axis_tuser),
    .m_tlast_o   (m_axis_tlast)
  );

endmodule
